FILE: src/scfl_pkg.sv
// ---------------------------------------------------------------------------
// scfl_pkg
// Shared types, constants and the FNV-1a step for the sampled frame change
// latch.
// ---------------------------------------------------------------------------
package scfl_pkg;

  localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [15:0] STRIDE_RESET = 16'd251;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_REARM = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // One accepted item moving out of the input register.
  typedef struct packed {
    logic       go;
    logic [1:0] opcode;
    logic [7:0] frame_byte;
    logic       last_byte;
  } scfl_step_t;

  // Summary of a frame at its last byte.
  typedef struct packed {
    logic        done;
    logic        skipped;
    logic        nonzero;
    logic [63:0] sig;
  } scfl_frame_end_t;

  // Multiply by the FNV prime 2^40 + 2^8 + 0xb3, as shifts and adds.
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: src/sampled_frame_change_latch_top.sv
// ---------------------------------------------------------------------------
// sampled_frame_change_latch_top
// Samples framebuffer bytes at a stride, hashes them with FNV-1a and decides
// per frame whether fresh content is latched.
// ---------------------------------------------------------------------------
// Takes one item per clock: every item passes an input register and is
// processed from there by a single pass of stride, hash and decision
// logic, whose answer lands in an output register. Throughput is one item per
// cycle while the output side takes results; a result waiting in the output
// register stalls only an item that itself produces a result. out_valid is
// set from the output register when the item leaves the input register.
// The hash step (a 64-bit multiply by the FNV prime, built as shifts and adds)
// plus the baseline compare sets the cycle time. A result appears for each
// last frame byte and each probe; rearm and unused opcodes give none.
// sample_stride may be written only while the block is idle; zero acts as one.
module sampled_frame_change_latch_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_content_latched,
  output logic [63:0] out_frame_signature,
  output logic        out_signature_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_sample_stride
);

  logic [15:0] stride_r;

  logic        in_valid_r, in_valid_nxt;
  logic [1:0]  op_r;
  logic [7:0]  byte_r;
  logic        last_r;

  logic        out_valid_r, out_valid_nxt;
  logic        latched_r;
  logic [63:0] sig_r;
  logic        sig_ok_r;

  logic        has_result;
  logic        out_free;
  logic        advance;
  logic        is_probe;
  logic        latch_flag;
  logic        got;

  scfl_pkg::scfl_step_t      step;
  scfl_pkg::scfl_frame_end_t frame_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= scfl_pkg::STRIDE_RESET;
    end else if (cfg_valid) begin
      stride_r <= cfg_sample_stride;
    end
  end

  // input register
  always_comb begin
    is_probe   = (op_r == scfl_pkg::OP_PROBE);
    has_result = is_probe || ((op_r == scfl_pkg::OP_FRAME) && last_r);
    out_free   = !out_valid_r || out_ready;
    advance    = in_valid_r && (!has_result || out_free);
    in_ready   = !in_valid_r || advance;
    in_valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      byte_r <= in_frame_byte;
      last_r <= in_last_byte;
    end
  end

  always_comb begin
    step.go         = advance;
    step.opcode     = op_r;
    step.frame_byte = byte_r;
    step.last_byte  = last_r;
  end

  scfl_frame_acc u_frame_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .sample_stride (stride_r),
    .latch_flag    (latch_flag),
    .frame_end     (frame_end)
  );

  scfl_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .frame_end  (frame_end),
    .latch_flag (latch_flag),
    .got        (got)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && has_result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      if (is_probe) begin
        latched_r <= latch_flag;
        sig_r     <= 64'd0;
        sig_ok_r  <= 1'b0;
      end else if (frame_end.skipped) begin
        latched_r <= 1'b1;
        sig_r     <= 64'd0;
        sig_ok_r  <= 1'b0;
      end else begin
        latched_r <= got;
        sig_r     <= frame_end.sig;
        sig_ok_r  <= 1'b1;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_content_latched = latched_r;
  assign out_frame_signature = sig_r;
  assign out_signature_valid = sig_ok_r;

  a_skip_sig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !sig_ok_r) |-> (sig_r == 64'd0))
    else $error("skipped frame or probe carries a signature");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && has_result) |-> out_free)
    else $error("result register overwritten before transfer");

endmodule

FILE: src/scfl_frame_acc.sv
// ---------------------------------------------------------------------------
// scfl_frame_acc
// Walks the bytes of a frame: stride sampling, nonzero tracking and the
// running FNV-1a signature. Reports a frame summary at the last byte.
// ---------------------------------------------------------------------------
module scfl_frame_acc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  scfl_pkg::scfl_step_t      step,
  input  logic [15:0]               sample_stride,
  input  logic                      latch_flag,
  output scfl_pkg::scfl_frame_end_t frame_end
);

  logic        open_r, open_nxt;
  logic        skip_r, skip_nxt;
  logic        nz_r, nz_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [63:0] sig_r, sig_nxt;

  logic [15:0] stride;
  logic [15:0] pos_eff;
  logic [16:0] pos_inc;
  logic        skip_now;
  logic        sample;
  logic [63:0] sig_upd;
  logic        nz_upd;
  logic [15:0] pos_upd;

  always_comb begin
    stride   = (sample_stride == 16'd0) ? 16'd1 : sample_stride;
    pos_eff  = (pos_r >= stride) ? 16'd0 : pos_r;
    sample   = (pos_eff == 16'd0);
    pos_inc  = {1'b0, pos_eff} + 17'd1;
    pos_upd  = (pos_inc >= {1'b0, stride}) ? 16'd0 : pos_inc[15:0];
    skip_now = open_r ? skip_r : latch_flag;
    sig_upd  = sample ? scfl_pkg::fnv_mul(sig_r ^ {56'd0, step.frame_byte}) : sig_r;
    nz_upd   = nz_r | (sample && (step.frame_byte != 8'd0));
  end

  always_comb begin
    open_nxt = open_r;
    skip_nxt = skip_r;
    nz_nxt   = nz_r;
    pos_nxt  = pos_r;
    sig_nxt  = sig_r;
    if (step.go) begin
      unique case (step.opcode)
        scfl_pkg::OP_FRAME: begin
          if (step.last_byte) begin
            open_nxt = 1'b0;
            skip_nxt = 1'b0;
            nz_nxt   = 1'b0;
            pos_nxt  = 16'd0;
            sig_nxt  = scfl_pkg::FNV_BASIS;
          end else begin
            open_nxt = 1'b1;
            skip_nxt = skip_now;
            if (!skip_now) begin
              nz_nxt  = nz_upd;
              pos_nxt = pos_upd;
              sig_nxt = sig_upd;
            end
          end
        end
        scfl_pkg::OP_REARM: begin
          // abandon any open frame
          open_nxt = 1'b0;
          skip_nxt = 1'b0;
          nz_nxt   = 1'b0;
          pos_nxt  = 16'd0;
          sig_nxt  = scfl_pkg::FNV_BASIS;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      skip_r <= 1'b0;
      nz_r   <= 1'b0;
      pos_r  <= 16'd0;
      sig_r  <= scfl_pkg::FNV_BASIS;
    end else begin
      open_r <= open_nxt;
      skip_r <= skip_nxt;
      nz_r   <= nz_nxt;
      pos_r  <= pos_nxt;
      sig_r  <= sig_nxt;
    end
  end

  always_comb begin
    frame_end.done    = step.go && (step.opcode == scfl_pkg::OP_FRAME) && step.last_byte;
    frame_end.skipped = skip_now;
    frame_end.nonzero = nz_upd;
    frame_end.sig     = sig_upd;
  end

endmodule

FILE: src/scfl_decide.sv
// ---------------------------------------------------------------------------
// scfl_decide
// Latch decision at the end of a walked frame: baseline after rearm,
// rebase on an all-zero frame, no latch on a frame equal to the baseline.
// ---------------------------------------------------------------------------
module scfl_decide (
  input  logic                      clk,
  input  logic                      rst_n,
  input  scfl_pkg::scfl_step_t      step,
  input  scfl_pkg::scfl_frame_end_t frame_end,
  output logic                      latch_flag,
  output logic                      got
);

  logic        latch_r, latch_nxt;
  logic        rearmed_r, rearmed_nxt;
  logic        base_ok_r, base_ok_nxt;
  logic [63:0] base_sig_r, base_sig_nxt;
  logic        fall_thru;

  always_comb begin
    latch_nxt    = latch_r;
    rearmed_nxt  = rearmed_r;
    base_ok_nxt  = base_ok_r;
    base_sig_nxt = base_sig_r;
    got          = 1'b0;
    fall_thru    = 1'b0;

    if (rearmed_r) begin
      if (!base_ok_r) begin
        base_sig_nxt = frame_end.sig;
        base_ok_nxt  = 1'b1;
      end else if (!frame_end.nonzero) begin
        base_sig_nxt = frame_end.sig;
      end else if (frame_end.sig != base_sig_r) begin
        rearmed_nxt = 1'b0;
        base_ok_nxt = 1'b0;
        fall_thru   = 1'b1;
      end
    end else begin
      fall_thru = 1'b1;
    end

    if (fall_thru && frame_end.nonzero) begin
      latch_nxt = 1'b1;
      got       = 1'b1;
    end

    // commit only for a walked frame's last byte
    if (!(frame_end.done && !frame_end.skipped)) begin
      latch_nxt    = latch_r;
      rearmed_nxt  = rearmed_r;
      base_ok_nxt  = base_ok_r;
      base_sig_nxt = base_sig_r;
    end

    if (step.go && (step.opcode == scfl_pkg::OP_REARM)) begin
      latch_nxt   = 1'b0;
      rearmed_nxt = 1'b1;
      base_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r    <= 1'b0;
      rearmed_r  <= 1'b0;
      base_ok_r  <= 1'b0;
      base_sig_r <= 64'd0;
    end else begin
      latch_r    <= latch_nxt;
      rearmed_r  <= rearmed_nxt;
      base_ok_r  <= base_ok_nxt;
      base_sig_r <= base_sig_nxt;
    end
  end

  assign latch_flag = latch_r;

  a_latch_excl_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    !(latch_r && rearmed_r))
    else $error("latch and rearm phase both set");

  a_base_in_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    base_ok_r |-> rearmed_r)
    else $error("baseline held outside rearm phase");

  a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step.go && step.opcode == scfl_pkg::OP_REARM) |=> (!latch_r && rearmed_r))
    else $error("rearm did not clear the latch");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for sampled_frame_change_latch_top. Frame bytes, rearms, probes
// and unused opcodes are streamed through the valid/ready input. The run
// covers the reset stride and a set of strides that includes 0, 1 and 65535.
// A scoreboard tracks the latch, baseline and FNV-1a state. It compares each
// result with the answer it predicted for the oldest outstanding frame end
// or probe.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
  localparam int          HOLD_CYCLES = 120;
  localparam int          PHASE_ITEMS = 270;

  typedef struct {
    logic        latched;
    logic [63:0] sig;
    logic        valid;
  } frame_answer_t;

  class latch_scoreboard;
    logic [15:0]   stride;
    logic          latch_flag, rearmed, have_baseline;
    logic          any_nz, skipping, frame_open;
    logic [63:0]   baseline, run_sig;
    logic [15:0]   pos;
    frame_answer_t answers_due[$];
    int            errors, checked, hashed, skipped, latches, probes;

    function new();
      stride        = scfl_pkg::STRIDE_RESET;
      latch_flag    = 1'b0;
      rearmed       = 1'b0;
      have_baseline = 1'b0;
      baseline      = '0;
      clear_frame();
    endfunction

    function void set_stride(logic [15:0] v);
      stride = v;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function void clear_frame();
      run_sig    = scfl_pkg::FNV_BASIS;
      any_nz     = 1'b0;
      pos        = '0;
      skipping   = 1'b0;
      frame_open = 1'b0;
    endfunction

    // Latch decision at the end of a hashed frame.
    function logic decide();
      if (rearmed) begin
        if (!have_baseline) begin
          baseline      = run_sig;
          have_baseline = 1'b1;
          return 1'b0;
        end
        if (!any_nz) begin
          baseline = run_sig;
          return 1'b0;
        end
        if (run_sig == baseline) return 1'b0;
        rearmed       = 1'b0;
        have_baseline = 1'b0;
      end
      if (!any_nz) return 1'b0;
      latch_flag = 1'b1;
      return 1'b1;
    endfunction

    function void note_item(logic [1:0] op, logic [7:0] b, logic last);
      int            eff;
      int            nxt;
      frame_answer_t a;
      case (op)
        scfl_pkg::OP_REARM: begin
          have_baseline = 1'b0;
          rearmed       = 1'b1;
          latch_flag    = 1'b0;
          clear_frame();
        end
        scfl_pkg::OP_PROBE: begin
          a = '{latch_flag, 64'd0, 1'b0};
          answers_due.push_back(a);
          probes++;
        end
        scfl_pkg::OP_FRAME: begin
          if (!frame_open) begin
            frame_open = 1'b1;
            skipping   = latch_flag;
          end
          if (!skipping) begin
            eff = (stride == 16'd0) ? 1 : int'(stride);
            // wrap a position left beyond a freshly shortened stride
            if (int'(pos) >= eff) pos = '0;
            if (pos == 16'd0) begin
              if (b != 8'd0) any_nz = 1'b1;
              run_sig = (run_sig ^ {56'd0, b}) * FNV_PRIME;
            end
            nxt = int'(pos) + 1;
            pos = (nxt >= eff) ? 16'd0 : 16'(nxt);
          end
          if (last) begin
            if (skipping) begin
              a = '{1'b1, 64'd0, 1'b0};
              skipped++;
            end else begin
              a.sig     = run_sig;
              a.latched = decide();
              a.valid   = 1'b1;
              hashed++;
              if (a.latched) latches++;
            end
            answers_due.push_back(a);
            clear_frame();
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_answer(logic latched, logic [63:0] sig, logic valid);
      frame_answer_t a;
      checked++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result latched=%b sig=%h valid=%b",
                                  latched, sig, valid));
        return;
      end
      a = answers_due.pop_front();
      if (latched !== a.latched)
        report_mismatch($sformatf("content_latched %b, want %b", latched, a.latched));
      if (sig !== a.sig)
        report_mismatch($sformatf("frame_signature %h, want %h", sig, a.sig));
      if (valid !== a.valid)
        report_mismatch($sformatf("signature_valid %b, want %b", valid, a.valid));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = scfl_pkg::OP_FRAME;
  logic [7:0]  in_frame_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_content_latched;
  logic [63:0] out_frame_signature;
  logic        out_signature_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_sample_stride = scfl_pkg::STRIDE_RESET;

  latch_scoreboard sb = new();

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_active = 1'b0;
  int          items_sent = 0;
  logic [7:0]  last_frame[$];

  sampled_frame_change_latch_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_frame_byte       (in_frame_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_content_latched (out_content_latched),
    .out_frame_signature (out_frame_signature),
    .out_signature_valid (out_signature_valid),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_sample_stride   (cfg_sample_stride)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_opcode, in_frame_byte, in_last_byte);
      if (out_valid && out_ready)
        sb.check_answer(out_content_latched, out_frame_signature, out_signature_valid);
    end
  end

  // Result side: random ready bursts (ready held high when idling is off), one long hold-off on request.
  initial begin : result_side
    int n;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_ready   = 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end else if (!rx_idle_on) begin
        @(negedge clk) out_ready = 1'b1;
      end else begin
        n = $urandom_range(1, 24);
        @(negedge clk) out_ready = 1'b1;
        repeat (n - 1) @(negedge clk);
        if ($urandom_range(0, 1) == 1) begin
          n = $urandom_range(1, 19);
          @(negedge clk) out_ready = 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic last);
    int n;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk) in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_opcode     = op;
    in_frame_byte = b;
    in_last_byte  = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk) in_valid = 1'b0;
  endtask

  task automatic drain_results();
    release_input();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_stride(input logic [15:0] v);
    drain_results();
    // let a trailing no-result item clear the two-stage pipe
    repeat (4) @(negedge clk);
    cfg_valid         = 1'b1;
    cfg_sample_stride = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_stride(v);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // Hold the result side off while probes keep coming, so the pipe fills.
  task automatic hold_off_burst();
    bit saved;
    saved = tx_idle_on;
    release_input();
    hold_req = 1'b1;
    while (!hold_active) @(negedge clk);
    tx_idle_on = 1'b0;
    repeat (30) send_item(scfl_pkg::OP_PROBE, 8'($urandom), 1'($urandom));
    tx_idle_on = saved;
  endtask

  task automatic send_frame(input int max_len);
    logic [7:0] bytes[$];
    int         len, r, kind, i;
    r = $urandom_range(0, 99);
    if (r < 40)      len = $urandom_range(1, 4);
    else if (r < 85) len = $urandom_range(5, 24);
    else             len = $urandom_range(25, max_len);
    kind = $urandom_range(0, 99);
    if (kind < 30 && last_frame.size() > 0) begin
      bytes = last_frame;
    end else begin
      for (i = 0; i < len; i++) begin
        if (kind < 45)      bytes.push_back(8'd0);
        else if (kind < 70) bytes.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'd0);
        else                bytes.push_back(8'($urandom));
      end
    end
    for (i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 99) < 2)
        send_item(scfl_pkg::OP_PROBE, 8'($urandom), 1'($urandom));
      // abandon the frame now and then
      if (i > 0 && $urandom_range(0, 199) == 0) begin
        send_item(scfl_pkg::OP_REARM, 8'($urandom), 1'($urandom));
        return;
      end
      send_item(scfl_pkg::OP_FRAME, bytes[i], i == bytes.size() - 1);
    end
    last_frame = bytes;
  endtask

  task automatic run_phase(input int n, input int max_len, input bit do_hold,
                           input bit do_pause);
    int start, r;
    bit midway;
    start  = items_sent;
    midway = 1'b0;
    while (items_sent - start < n) begin
      if (!midway && items_sent - start >= n / 2) begin
        midway = 1'b1;
        if (do_hold) hold_off_burst();
        if (do_pause) drain_results();
      end
      r = $urandom_range(0, 99);
      if (r < 7)       send_item(scfl_pkg::OP_REARM, 8'($urandom), 1'($urandom));
      else if (r < 14) send_item(scfl_pkg::OP_PROBE, 8'($urandom), 1'($urandom));
      else if (r < 16) send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
      else             send_frame(max_len);
    end
  endtask

  task automatic directed();
    send_item(scfl_pkg::OP_PROBE, 8'h00, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'hFF, 1'b1);      // single-byte frame latches
    send_item(scfl_pkg::OP_PROBE, 8'hFF, 1'b1);
    send_item(scfl_pkg::OP_FRAME, 8'h00, 1'b0);      // skipped while latched
    send_item(scfl_pkg::OP_FRAME, 8'h12, 1'b1);
    send_item(OP_UNUSED, 8'hAA, 1'b1);
    send_item(scfl_pkg::OP_REARM, 8'h55, 1'b1);
    send_item(scfl_pkg::OP_PROBE, 8'h00, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'h80, 1'b0);      // baseline, second byte not sampled
    send_item(scfl_pkg::OP_FRAME, 8'h33, 1'b1);
    send_item(scfl_pkg::OP_FRAME, 8'h80, 1'b1);      // equals baseline
    send_item(scfl_pkg::OP_FRAME, 8'h00, 1'b1);      // all zero rebases
    send_item(scfl_pkg::OP_FRAME, 8'h01, 1'b1);
    write_stride(16'd0);
    send_item(scfl_pkg::OP_REARM, 8'h00, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'h00, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'hFF, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'h7F, 1'b1);
    // shorten the stride with a frame open
    write_stride(16'd5);
    send_item(scfl_pkg::OP_FRAME, 8'h11, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'h22, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'h33, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'h44, 1'b0);
    write_stride(16'd2);
    send_item(scfl_pkg::OP_FRAME, 8'h55, 1'b0);
    send_item(scfl_pkg::OP_FRAME, 8'hAA, 1'b1);
    send_item(scfl_pkg::OP_PROBE, 8'h00, 1'b1);
  endtask

  initial begin : stimulus
    logic [15:0] strides[7];
    int          k;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    directed();
    strides = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'($urandom_range(4, 16)), 16'd251};
    for (k = 0; k < 7; k++) begin
      write_stride(strides[k]);
      // no idling in the closing phase
      if (k == 6) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      run_phase(PHASE_ITEMS, (strides[k] > 16'd100) ? 600 : 80, k == 1, k == 3);
    end
    drain_results();
    repeat (10) @(negedge clk);
    $display("tb: %0d items driven, %0d results checked over strides 251, 0..3, %0d, 65535",
             items_sent, sb.checked, strides[5]);
    $display("tb: %0d frames hashed, %0d skipped while latched, %0d latch events, %0d probes",
             sb.hashed, sb.skipped, sb.latches, sb.probes);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
src/scfl_pkg.sv
src/scfl_frame_acc.sv
src/scfl_decide.sv
src/sampled_frame_change_latch_top.sv
dv/tb.sv
